### design/slsf_pkg.sv
// Shared types and codes for the sync/length/checksum frame receiver.
// No dependencies; used by the front end, the command queue, the back end and the top level.
`default_nettype none

package slsf_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_DATA     = 2'd0;
    localparam kind_t KIND_BAD_SUM  = 2'd1;
    localparam kind_t KIND_TOO_LONG = 2'd2;

    // Count width covers the full payload limit range (up to 127 bytes)
    localparam int CNT_W = 7;

    // Command handed from the front end to the back end
    typedef struct packed {
        kind_t            kind;
        logic [CNT_W-1:0] count;
        logic             bank;
    } cmd_t;

    // Bank release from the back end once the last byte of a frame is read out
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

endpackage

`default_nettype wire

### design/slsf_front.sv
// Front end: sync hunt, length check, checksum and payload store writes.
// Depends on slsf_pkg; feeds slsf_queue and the payload store in slsf_back.
`default_nettype none

module slsf_front #(
    parameter int MAX_PAYLOAD = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    input  wire logic [7:0]                           cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [7:0]                           rx_byte,
    input  wire logic                                 q_full,
    output logic                                      push,
    output slsf_pkg::cmd_t                            push_cmd,
    input  wire slsf_pkg::rel_t                       rel,
    output logic                                      wr_en,
    output logic [$clog2(2*MAX_PAYLOAD)-1:0]          wr_addr,
    output logic [7:0]                                wr_data
);

    localparam int POS_W  = $clog2(MAX_PAYLOAD + 3);
    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 2);
    localparam int ADDR_W = $clog2(2 * MAX_PAYLOAD);

    logic [7:0]       sync_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       sum_reg, sum_next;
    logic             wbank_reg, wbank_next;
    logic [1:0]       busy_reg, busy_next;

    logic             accept;
    logic [ADDR_W-1:0] slot;

    always_comb
    begin
        if (pos_reg == POS_W'(0))
            in_ready = 1'b1;
        else if (pos_reg == POS_W'(1))
            in_ready = !q_full;
        else
            in_ready = !q_full && !busy_reg[wbank_reg];
    end

    assign accept  = in_valid && in_ready;
    assign slot    = ADDR_W'(pos_reg - POS_W'(2));
    assign wr_addr = wbank_reg ? ADDR_W'(MAX_PAYLOAD) + slot : slot;
    assign wr_data = rx_byte;

    always_comb
    begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        wbank_next = wbank_reg;
        busy_next  = busy_reg;
        push       = 1'b0;
        push_cmd   = '{kind: slsf_pkg::KIND_BAD_SUM, count: '0, bank: wbank_reg};
        wr_en      = 1'b0;

        if (rel.valid)
            busy_next[rel.bank] = 1'b0;

        if (accept)
        begin
            if (pos_reg == POS_W'(0))
            begin
                if (rx_byte == sync_reg)
                begin
                    sum_next = sync_reg;
                    pos_next = POS_W'(1);
                end
            end
            else if (pos_reg == POS_W'(1))
            begin
                len_next = LEN_W'(rx_byte);
                sum_next = sum_reg + rx_byte;
                if (rx_byte == 8'd0)
                begin
                    push     = 1'b1;
                    pos_next = '0;
                end
                else if (rx_byte > 8'(MAX_PAYLOAD + 1))
                begin
                    push          = 1'b1;
                    push_cmd.kind = slsf_pkg::KIND_TOO_LONG;
                    pos_next      = '0;
                end
                else
                    pos_next = POS_W'(2);
            end
            else if (pos_reg == POS_W'(len_reg) + POS_W'(1))
            begin
                // check byte
                pos_next = '0;
                if (sum_reg != rx_byte)
                    push = 1'b1;
                else if (len_reg != LEN_W'(1))
                begin
                    push                 = 1'b1;
                    push_cmd.kind        = slsf_pkg::KIND_DATA;
                    push_cmd.count       = slsf_pkg::CNT_W'(len_reg) - slsf_pkg::CNT_W'(1);
                    busy_next[wbank_reg] = 1'b1;
                    wbank_next           = !wbank_reg;
                end
            end
            else
            begin
                wr_en    = 1'b1;
                sum_next = sum_reg + rx_byte;
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg  <= 8'hFD;
            pos_reg   <= '0;
            len_reg   <= '0;
            sum_reg   <= '0;
            wbank_reg <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
                sync_reg <= cfg_data;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            wbank_reg <= wbank_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

`default_nettype wire

### design/slsf_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on slsf_pkg for the command type.
`default_nettype none

module slsf_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire slsf_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                q_valid,
    output slsf_pkg::cmd_t      q_cmd
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    slsf_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full    = cnt_reg == CNT_W'(DEPTH);
    assign q_valid = cnt_reg != '0;
    assign q_cmd   = entry_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + PTR_W'(1);
            if (pop)
                rptr_reg <= rptr_reg + PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### design/slsf_back.sv
// Back end: two-bank payload store and the result sequencer with its output register.
// Depends on slsf_pkg; takes commands from slsf_queue and store writes from slsf_front.
`default_nettype none

module slsf_back #(
    parameter int MAX_PAYLOAD = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(2*MAX_PAYLOAD)-1:0] wr_addr,
    input  wire logic [7:0]                       wr_data,
    input  wire logic                             q_valid,
    input  wire slsf_pkg::cmd_t                   q_cmd,
    output logic                                  pop,
    output slsf_pkg::rel_t                        rel,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output slsf_pkg::kind_t                       kind,
    output logic [7:0]                            payload_byte,
    output logic [3:0]                            byte_index,
    output logic                                  last
);

    localparam int ADDR_W = $clog2(2 * MAX_PAYLOAD);
    localparam int DEPTH  = 2 * MAX_PAYLOAD;
    localparam int CW     = slsf_pkg::CNT_W;

    logic [7:0] mem [DEPTH];

    logic          active_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] n_reg;
    logic          bank_reg;

    logic            out_valid_reg;
    slsf_pkg::kind_t kind_reg;
    logic [3:0]      index_reg;
    logic            last_reg;
    logic [7:0]      rd_data_reg;

    logic            slot_free, issue, cur_last, cur_bank;
    slsf_pkg::kind_t cur_kind;
    logic [CW-1:0]   cur_idx, cur_n;
    logic [ADDR_W-1:0] rd_addr;

    assign slot_free = !out_valid_reg || out_ready;
    assign issue     = slot_free && (active_reg || q_valid);
    assign pop       = issue && !active_reg;

    assign cur_kind = active_reg ? slsf_pkg::KIND_DATA : q_cmd.kind;
    assign cur_idx  = active_reg ? idx_reg : '0;
    assign cur_n    = active_reg ? n_reg : q_cmd.count;
    assign cur_bank = active_reg ? bank_reg : q_cmd.bank;
    assign cur_last = (cur_kind != slsf_pkg::KIND_DATA) || (cur_idx + CW'(1) == cur_n);
    assign rd_addr  = cur_bank ? ADDR_W'(MAX_PAYLOAD) + ADDR_W'(cur_idx) : ADDR_W'(cur_idx);

    // bank is free once its last byte has been read into the output register
    assign rel.valid = issue && cur_kind == slsf_pkg::KIND_DATA && cur_last;
    assign rel.bank  = cur_bank;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (issue && cur_kind == slsf_pkg::KIND_DATA)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            kind_reg  <= cur_kind;
            index_reg <= (cur_kind == slsf_pkg::KIND_DATA) ? cur_idx[3:0] : 4'd0;
            last_reg  <= cur_last;
            idx_reg   <= cur_idx + CW'(1);
            n_reg     <= cur_n;
            bank_reg  <= cur_bank;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                out_valid_reg <= 1'b1;
                active_reg    <= (cur_kind == slsf_pkg::KIND_DATA) && !cur_last;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign byte_index   = index_reg;
    assign last         = last_reg;
    assign payload_byte = (kind_reg == slsf_pkg::KIND_DATA) ? rd_data_reg : 8'd0;

endmodule

`default_nettype wire

### design/sync_length_sum_frame_receiver_top.sv
// Top level of the sync/length/checksum frame receiver.
// Depends on slsf_pkg, slsf_front, slsf_queue and slsf_back.
`default_nettype none

// Takes one received byte per transaction and hunts for the sync byte (sync_value, reset 0xFD),
// then a length byte L, L-1 payload bytes and a check byte that must equal the 8-bit sum of
// sync, L and payload. A byte is accepted each cycle while the front end parses, unless stalled
// as below; on the check byte a good frame delivers its L-1 payload bytes (up to MAX_PAYLOAD)
// one per cycle from the output register while out_ready is high, the final one
// marked last. A bad sum, or L of zero, gives one checksum-error result; an L above
// MAX_PAYLOAD+1 gives one length-too-large result. The store has two banks, so the next frame
// is parsed while the previous one drains. Bytes after the sync byte stall while the two-entry
// command queue is full, and payload bytes also while both banks are still waiting to be read
// out. cfg_ready is always high and a new sync value takes effect from the next hunt.
module sync_length_sum_frame_receiver_top #(
    parameter int MAX_PAYLOAD = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] sync_value,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      payload_byte,
    output logic [3:0]      byte_index,
    output logic            last
);

    localparam int ADDR_W = $clog2(2 * MAX_PAYLOAD);

    logic              q_full, push, pop, q_valid, wr_en;
    slsf_pkg::cmd_t    push_cmd, q_cmd;
    slsf_pkg::rel_t    rel;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    assign cfg_ready = 1'b1;

    slsf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (sync_value),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd),
        .rel       (rel),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    slsf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    slsf_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .pop          (pop),
        .rel          (rel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .last         (last)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("command pushed into full queue");

    a_error_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != slsf_pkg::KIND_DATA |-> last && payload_byte == 8'd0
            && byte_index == 4'd0)
        else $error("error result not a clean run of one");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("back end popped an empty queue");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the sync/length/checksum frame receiver.
// Depends on slsf_pkg and sync_length_sum_frame_receiver_top; predicts every result in-line.
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_PAYLOAD  = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT  = 2000;
    localparam logic [7:0] SYNC_AT_RESET = 8'hFD;
    localparam logic [4:0] POS_HUNT      = 5'd0;
    localparam logic [4:0] POS_LENGTH    = 5'd1;
    localparam logic [4:0] POS_FIRST_PAY = 5'd2;

    typedef struct packed {
        slsf_pkg::kind_t kind;
        logic [7:0]      data;
        logic [3:0]      idx;
        logic            last;
    } rx_result_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_valid  = 1'b0;
    logic       cfg_ready;
    logic [7:0] sync_value = 8'h00;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte    = 8'h00;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [3:0] byte_index;
    logic       last;

    // Shadow of the receiver state
    logic [7:0] sync_shadow = SYNC_AT_RESET;
    logic [4:0] rx_pos      = POS_HUNT;
    logic [7:0] frame_len   = 8'd0;
    logic [7:0] sum_acc     = 8'd0;
    logic [7:0] body_store [MAX_PAYLOAD];

    rx_result_t frame_results_due[$];
    int  frame_items  = 0;
    int  mismatches   = 0;
    int  stall_left   = 0;
    int  quiet_cycles = 0;
    bit  idling_on    = 1'b1;

    sync_length_sum_frame_receiver_top #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .sync_value   (sync_value),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .last         (last)
    );

    always #10 clk = ~clk;

    function automatic void push_status(input slsf_pkg::kind_t k);
        rx_result_t r;
        r.kind = k;
        r.data = 8'd0;
        r.idx  = 4'd0;
        r.last = 1'b1;
        frame_results_due.push_back(r);
    endfunction

    // Advance the shadow parser by one received byte, queueing what it yields
    function automatic void parse_rx_byte(input logic [7:0] b);
        rx_result_t r;
        int count;
        if (rx_pos == POS_HUNT)
        begin
            if (b == sync_shadow)
            begin
                sum_acc = sync_shadow;
                rx_pos  = POS_LENGTH;
            end
            return;
        end
        if (rx_pos == POS_LENGTH)
        begin
            frame_len = b;
            sum_acc   = sum_acc + b;
            if (b == 8'd0)
            begin
                rx_pos = POS_HUNT;
                push_status(slsf_pkg::KIND_BAD_SUM);
            end
            else if (int'(b) > MAX_PAYLOAD + 1)
            begin
                rx_pos = POS_HUNT;
                push_status(slsf_pkg::KIND_TOO_LONG);
            end
            else
                rx_pos = POS_FIRST_PAY;
            return;
        end
        if (int'(rx_pos) >= int'(frame_len) + 1)
        begin
            rx_pos = POS_HUNT;
            if (sum_acc != b)
            begin
                push_status(slsf_pkg::KIND_BAD_SUM);
                return;
            end
            count = int'(frame_len) - 1;
            for (int k = 0; k < count; k++)
            begin
                r.kind = slsf_pkg::KIND_DATA;
                r.data = body_store[k];
                r.idx  = 4'(k);
                r.last = (k == count - 1);
                frame_results_due.push_back(r);
            end
            return;
        end
        body_store[4'(rx_pos - POS_FIRST_PAY)] = b;
        sum_acc = sum_acc + b;
        rx_pos  = rx_pos + 5'd1;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        if (!(rx_pos == POS_HUNT && b != sync_shadow))
            frame_items++;
        parse_rx_byte(b);
    endtask

    // Sync, length, len-1 body bytes and the check byte; stops after the
    // length byte when the length is rejected outright
    task automatic send_frame(input logic [7:0] len, input logic [7:0] body [MAX_PAYLOAD],
                              input bit corrupt);
        logic [7:0] sum;
        sum = sync_shadow + len;
        send_byte(sync_shadow);
        send_byte(len);
        if (len == 8'd0 || int'(len) > MAX_PAYLOAD + 1)
            return;
        for (int k = 0; k < int'(len) - 1; k++)
        begin
            sum = sum + body[k];
            send_byte(body[k]);
        end
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sync(input logic [7:0] v);
        cfg_valid  <= 1'b1;
        sync_value <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        sync_shadow = v;
    endtask

    task automatic test_short_frames();
        logic [7:0] body [MAX_PAYLOAD];
        foreach (body[k])
            body[k] = 8'd0;
        send_byte(8'h00);                       // ignored while hunting
        send_frame(8'd1, body, 1'b0);           // good, no payload, no result
        send_frame(8'd1, body, 1'b1);           // bad sum on an empty frame
        send_frame(8'd0, body, 1'b0);           // zero length always fails
        send_frame(8'(MAX_PAYLOAD + 2), body, 1'b0);
        wait_until_drained();
    endtask

    task automatic test_longest_frame();
        logic [7:0] body [MAX_PAYLOAD];
        foreach (body[k])
            body[k] = 8'(k * 17);
        body[3] = sync_shadow;                  // sync value inside the body is just data
        send_frame(8'(MAX_PAYLOAD + 1), body, 1'b0);
        wait_until_drained();
    endtask

    task automatic test_sync_register();
        logic [7:0] body [MAX_PAYLOAD];
        foreach (body[k])
            body[k] = 8'($urandom_range(0, 255));
        write_sync(8'h00);
        send_frame(8'd2, body, 1'b0);
        wait_until_drained();
        write_sync(8'hFF);
        send_frame(8'd3, body, 1'b0);
        send_byte(8'hFF);
        send_byte(8'd3);
        send_byte(8'h11);
        wait_until_drained();
        // change mid-frame: seeded sum stays, new value from the next hunt
        write_sync(8'h5A);
        send_byte(8'h22);
        send_byte(8'h35);
        send_byte(8'hFF);
        send_frame(8'd1, body, 1'b0);
        wait_until_drained();
    endtask

    task automatic test_random_traffic();
        logic [7:0] body [MAX_PAYLOAD];
        logic [7:0] len;
        int pick;
        int target;
        int trunc_n;
        for (int phase = 0; phase < 5; phase++)
        begin
            wait_until_drained();
            case (phase)
                0: write_sync(8'h00);
                1: write_sync(8'hFF);
                3: write_sync(SYNC_AT_RESET);
                default: write_sync(8'($urandom_range(0, 255)));
            endcase
            idling_on = (phase != 4);
            target = frame_items + 70;
            while (frame_items < target)
            begin
                foreach (body[k])
                    body[k] = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 9) == 0)
                    len = 8'($urandom_range(1, MAX_PAYLOAD + 1));
                else
                    len = 8'($urandom_range(1, 6));
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    send_frame(len, body, 1'b0);
                else if (pick < 77)
                    send_frame(len, body, 1'b1);
                else if (pick < 82)
                    send_frame(8'd0, body, 1'b0);
                else if (pick < 87)
                    send_frame(8'($urandom_range(MAX_PAYLOAD + 2, 255)), body, 1'b0);
                else if (pick < 94)
                begin
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom_range(0, 255)));
                end
                else
                begin
                    // truncated frame: later bytes get swallowed as body or check
                    len = 8'($urandom_range(3, MAX_PAYLOAD + 1));
                    trunc_n = $urandom_range(1, int'(len) - 2);
                    send_byte(sync_shadow);
                    send_byte(len);
                    for (int k = 0; k < trunc_n; k++)
                        send_byte(body[k]);
                end
            end
        end
    endtask

    // Output side: random stall bursts while idling is on
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (idling_on && $urandom_range(0, 11) == 0)
            stall_left = $urandom_range(1, 16);
        out_ready <= (stall_left == 0);
    end

    always @(posedge clk)
    begin
        rx_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_results_due.size() == 0)
            begin
                $error("unexpected result transaction: kind %0d payload_byte %0d", kind,
                       payload_byte);
                mismatches++;
            end
            else
            begin
                want = frame_results_due.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
                    mismatches++;
                end
                if (payload_byte !== want.data)
                begin
                    $error("payload_byte mismatch: expected %0d, actual %0d", want.data,
                           payload_byte);
                    mismatches++;
                end
                if (byte_index !== want.idx)
                begin
                    $error("byte_index mismatch: expected %0d, actual %0d", want.idx,
                           byte_index);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last mismatch: expected %0d, actual %0d", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_frames();
        test_longest_frame();
        test_sync_register();
        test_random_traffic();
        wait_until_drained();
        if (mismatches == 0 && frame_results_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
design/slsf_pkg.sv
design/slsf_front.sv
design/slsf_queue.sv
design/slsf_back.sv
design/sync_length_sum_frame_receiver_top.sv
tb/tb_top.sv
